// ===== sv/metf_pkg.sv =====
// ----------------------------------------------------------------------------
// metf_pkg
// Shared codes, field widths and the result item type of the edge twin finder.
// ----------------------------------------------------------------------------
package metf_pkg;

    // Field widths of the input item, the result item and the register.
    localparam int OP_W     = 2;
    localparam int FACET_W  = 8;
    localparam int SLOT_W   = 4;
    localparam int VID_W    = 16;
    localparam int COUNT_W  = 5;
    localparam int CFG_W    = 9;
    localparam int POS_W    = 4;

    // Operation codes carried in the op field.
    localparam logic [OP_W-1:0] OP_WRITE_VERTEX = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_COUNT    = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY        = 2'd2;

    // One result item, as it leaves the edge walker.
    typedef struct packed {
        logic [POS_W-1:0]   edge_position;
        logic [FACET_W-1:0] neighbor_facet;
        logic [POS_W-1:0]   neighbor_position;
        logic               found;
        logic               last;
    } t_result;

endpackage

// ===== sv/metf_vtx_ram.sv =====
// ----------------------------------------------------------------------------
// metf_vtx_ram
// Vertex store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module metf_vtx_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/metf_size_ram.sv =====
// ----------------------------------------------------------------------------
// metf_size_ram
// Facet vertex counts: a synchronous memory that is swept to zero after reset.
// ----------------------------------------------------------------------------
module metf_size_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 5
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata,
    output logic                     o_clr_busy
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;
    logic             r_clr_busy;
    logic [AW-1:0]    r_clr_addr;

    // Clearing pass: one entry per cycle from reset until the last entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Write port, shared between the clearing pass and count loads.
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clr_busy = r_clr_busy;

endmodule

// ===== sv/metf_walker.sv =====
// ----------------------------------------------------------------------------
// metf_walker
// Query sequencer: for each edge of the queried facet, scans the other facets
// slot by slot through the two memories and issues one result item; an empty or out-of-range facet gives a single item.
// ----------------------------------------------------------------------------
module metf_walker #(
    parameter int MAX_FACETS  = 256,
    parameter int MAX_VERTS   = 16,
    parameter int VERTEX_BITS = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // Query start, taken only while idle.
    input  logic                                       i_start,
    input  logic [metf_pkg::FACET_W-1:0]               i_facet,
    input  logic [metf_pkg::CFG_W-1:0]                 i_facets_in_use,
    output logic                                       o_busy,
    // Facet size memory read port.
    output logic                                       o_size_re,
    output logic [$clog2(MAX_FACETS)-1:0]              o_size_raddr,
    input  logic [$clog2(MAX_VERTS+1)-1:0]             i_size_rdata,
    // Vertex memory read port.
    output logic                                       o_vtx_re,
    output logic [$clog2(MAX_FACETS*MAX_VERTS)-1:0]    o_vtx_raddr,
    input  logic [VERTEX_BITS-1:0]                     i_vtx_rdata,
    // Result channel.
    output logic                                       o_res_valid,
    output metf_pkg::t_result                          o_res,
    input  logic                                       i_res_stall
);

    localparam int FW = $clog2(MAX_FACETS);
    localparam int JW = FW + 1;
    localparam int SW = $clog2(MAX_VERTS);
    localparam int CW = $clog2(MAX_VERTS + 1);
    localparam int AW = $clog2(MAX_FACETS * MAX_VERTS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_QSZ  = 3'd1;
    localparam logic [2:0] S_RD0  = 3'd2;
    localparam logic [2:0] S_RD1  = 3'd3;
    localparam logic [2:0] S_RD2  = 3'd4;
    localparam logic [2:0] S_FSZ  = 3'd5;
    localparam logic [2:0] S_SCAN = 3'd6;
    localparam logic [2:0] S_RES  = 3'd7;

    logic [2:0]             r_state;
    logic [FW-1:0]          r_qf;
    logic                   r_qok;
    logic [JW-1:0]          r_limit;
    logic [CW-1:0]          r_n;
    logic [SW-1:0]          r_e;
    logic [VERTEX_BITS-1:0] r_v0;
    logic [VERTEX_BITS-1:0] r_v1;
    logic [JW-1:0]          r_j;
    logic [CW-1:0]          r_k;
    logic [VERTEX_BITS-1:0] r_prev;
    logic [VERTEX_BITS-1:0] r_first;
    logic                   r_hit;
    logic [FW-1:0]          r_nb;
    logic [SW-1:0]          r_pos;
    logic                   r_ovalid;
    metf_pkg::t_result      r_out;

    logic [CW-1:0]          w_e1;
    logic [SW-1:0]          w_enx;
    logic [CW-1:0]          w_nj;
    logic [VERTEX_BITS-1:0] w_first;
    logic                   w_pair_hit;
    logic                   w_wrap_hit;
    logic                   w_load;
    logic                   w_last;

    // Vertex memory address of a slot in a facet.
    function automatic logic [AW-1:0] vaddr(input logic [FW-1:0] fac,
                                            input logic [SW-1:0] slot);
        vaddr = AW'(AW'(fac) * AW'(MAX_VERTS) + AW'(slot));
    endfunction

    // Edge end slot, wrapping to slot zero.
    assign w_e1  = CW'(r_e) + CW'(1);
    assign w_enx = (w_e1 < r_n) ? SW'(w_e1) : '0;

    // Scan comparisons on the slot whose data has just arrived.
    assign w_nj       = i_size_rdata;
    assign w_first    = (r_k == CW'(1)) ? i_vtx_rdata : r_first;
    assign w_pair_hit = (r_k >= CW'(2)) && (r_prev == r_v1) && (i_vtx_rdata == r_v0);
    assign w_wrap_hit = (r_k == w_nj) && (i_vtx_rdata == r_v1) && (w_first == r_v0);

    // Result hand-off into the output register.
    assign w_last = (r_n == '0) || (w_e1 == r_n);
    assign w_load = (r_state == S_RES) && (!r_ovalid || !i_res_stall);

    // Memory read requests.
    always_comb begin
        o_size_re    = 1'b0;
        o_size_raddr = r_j[FW-1:0];
        o_vtx_re     = 1'b0;
        o_vtx_raddr  = vaddr(r_j[FW-1:0], SW'(r_k));
        unique case (r_state)
            S_IDLE: begin
                o_size_re    = i_start;
                o_size_raddr = FW'(i_facet);
            end
            S_RD0: begin
                o_vtx_re    = 1'b1;
                o_vtx_raddr = vaddr(r_qf, r_e);
            end
            S_RD1: begin
                o_vtx_re    = 1'b1;
                o_vtx_raddr = vaddr(r_qf, w_enx);
            end
            S_FSZ: begin
                o_size_re = (r_j < r_limit) && (r_j[FW-1:0] != r_qf);
            end
            S_SCAN: begin
                o_vtx_re = (r_k < w_nj);
            end
            default: begin
            end
        endcase
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_qf    <= FW'(i_facet);
                        r_qok   <= 32'(i_facet) < 32'(MAX_FACETS);
                        r_limit <= (32'(i_facets_in_use) > 32'(MAX_FACETS)) ?
                                   JW'(MAX_FACETS) : JW'(i_facets_in_use);
                        r_state <= S_QSZ;
                    end
                end
                S_QSZ: begin
                    r_n   <= r_qok ? i_size_rdata : '0;
                    r_e   <= '0;
                    r_hit <= 1'b0;
                    if (!r_qok || i_size_rdata == '0) begin
                        r_state <= S_RES;
                    end else begin
                        r_state <= S_RD0;
                    end
                end
                S_RD0: begin
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_v0    <= i_vtx_rdata;
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_v1    <= i_vtx_rdata;
                    r_j     <= '0;
                    r_hit   <= 1'b0;
                    r_state <= S_FSZ;
                end
                S_FSZ: begin
                    r_k <= '0;
                    if (r_j >= r_limit) begin
                        r_state <= S_RES;
                    end else if (r_j[FW-1:0] == r_qf) begin
                        r_j <= r_j + JW'(1);
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_nj == '0) begin
                        r_j     <= r_j + JW'(1);
                        r_state <= S_FSZ;
                    end else begin
                        r_k <= r_k + CW'(1);
                        if (r_k != '0) begin
                            r_prev  <= i_vtx_rdata;
                            r_first <= w_first;
                        end
                        priority if (w_pair_hit) begin
                            r_hit   <= 1'b1;
                            r_nb    <= r_j[FW-1:0];
                            r_pos   <= SW'(r_k - CW'(1));
                            r_state <= S_RES;
                        end else if (w_wrap_hit) begin
                            r_hit   <= 1'b1;
                            r_nb    <= r_j[FW-1:0];
                            r_pos   <= '0;
                            r_state <= S_RES;
                        end else if (r_k == w_nj) begin
                            r_j     <= r_j + JW'(1);
                            r_state <= S_FSZ;
                        end else begin
                        end
                    end
                end
                S_RES: begin
                    if (w_load) begin
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_e     <= SW'(w_e1);
                            r_state <= S_RD0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register: loaded when empty or when its item is being taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_res_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.edge_position     <= metf_pkg::POS_W'(r_e);
            r_out.neighbor_facet    <= r_hit ? metf_pkg::FACET_W'(r_nb) : '0;
            r_out.neighbor_position <= r_hit ? metf_pkg::POS_W'(r_pos) : '0;
            r_out.found             <= r_hit;
            r_out.last              <= w_last;
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_ovalid;
    assign o_res       = r_out;

    // A query is only started while the sequencer is idle.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == S_IDLE)
        else $error("query started while walker busy");

    // The slot counter never runs past the scanned facet's size.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_k <= w_nj)
        else $error("scan slot counter past facet size");

    // The facet counter never runs past the search limit.
    a_facet_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FSZ |-> r_j <= r_limit)
        else $error("facet counter past search limit");

    // After the final result of a query the walker returns to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && w_last |=> r_state == S_IDLE && r_ovalid)
        else $error("walker not idle after final result");

endmodule

// ===== sv/mesh_edge_twin_finder_core.sv =====
// Operation: a load item is written to its memory as it is taken. A query reads the
//   queried facet's size, then per edge its two vertices, then the size and slots of
//   each other facet searched up to a hit, before the edge's result is registered.
// Throughput: one item at a time; the next is taken once a query's last result
//   is in the output register. Reset: control state clears at once, then the size
//   memory is swept to zero; items stall, config writes proceed.
// ----------------------------------------------------------------------------
// mesh_edge_twin_finder_core
// Half-edge twin finder: stores facets as vertex lists and, per query, reports
// for each edge the lowest other facet holding the reversed edge.
// ----------------------------------------------------------------------------
module mesh_edge_twin_finder_core #(
    parameter int MAX_FACETS  = 256,
    parameter int MAX_VERTS   = 16,
    parameter int VERTEX_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration port.
    input  logic                          i_cfg_we,
    input  logic [metf_pkg::CFG_W-1:0]    i_cfg_wdata,
    // Input channel.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [metf_pkg::OP_W-1:0]     i_op,
    input  logic [metf_pkg::FACET_W-1:0]  i_facet_index,
    input  logic [metf_pkg::SLOT_W-1:0]   i_slot,
    input  logic [metf_pkg::VID_W-1:0]    i_vertex_id,
    input  logic [metf_pkg::COUNT_W-1:0]  i_vertex_count,
    // Result channel.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [metf_pkg::POS_W-1:0]    o_edge_position,
    output logic [metf_pkg::FACET_W-1:0]  o_neighbor_facet,
    output logic [metf_pkg::POS_W-1:0]    o_neighbor_position,
    output logic                          o_found,
    output logic                          o_last
);

    localparam int FW = $clog2(MAX_FACETS);
    localparam int SW = $clog2(MAX_VERTS);
    localparam int CW = $clog2(MAX_VERTS + 1);
    localparam int AW = $clog2(MAX_FACETS * MAX_VERTS);

    logic [metf_pkg::CFG_W-1:0] r_facets_in_use;

    logic                   w_accept;
    logic                   w_facet_ok;
    logic                   w_slot_ok;
    logic                   w_start;
    logic                   w_busy;
    logic                   w_clr_busy;
    logic                   w_vtx_we;
    logic [AW-1:0]          w_vtx_waddr;
    logic [VERTEX_BITS-1:0] w_vtx_wdata;
    logic                   w_vtx_re;
    logic [AW-1:0]          w_vtx_raddr;
    logic [VERTEX_BITS-1:0] w_vtx_rdata;
    logic                   w_size_we;
    logic [CW-1:0]          w_size_wdata;
    logic                   w_size_re;
    logic [FW-1:0]          w_size_raddr;
    logic [CW-1:0]          w_size_rdata;
    metf_pkg::t_result      w_res;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_facets_in_use <= '0;
        end else if (i_cfg_we) begin
            r_facets_in_use <= i_cfg_wdata;
        end
    end

    // Input handshake: items are taken only while nothing else is in progress.
    assign o_in_stall = w_busy || w_clr_busy;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Load decode: out-of-range facets and slots leave the memories untouched.
    assign w_facet_ok  = 32'(i_facet_index) < 32'(MAX_FACETS);
    assign w_slot_ok   = 32'(i_slot) < 32'(MAX_VERTS);
    assign w_vtx_we    = w_accept && (i_op == metf_pkg::OP_WRITE_VERTEX) &&
                         w_facet_ok && w_slot_ok;
    assign w_vtx_waddr = AW'(AW'(FW'(i_facet_index)) * AW'(MAX_VERTS) +
                             AW'(SW'(i_slot)));
    assign w_vtx_wdata = VERTEX_BITS'(i_vertex_id);
    assign w_size_we   = w_accept && (i_op == metf_pkg::OP_SET_COUNT) && w_facet_ok;
    assign w_size_wdata = (32'(i_vertex_count) > 32'(MAX_VERTS)) ?
                          CW'(MAX_VERTS) : CW'(i_vertex_count);
    assign w_start     = w_accept && (i_op == metf_pkg::OP_QUERY);

    metf_vtx_ram #(
        .DEPTH (MAX_FACETS * MAX_VERTS),
        .WIDTH (VERTEX_BITS)
    ) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (w_vtx_we),
        .i_waddr (w_vtx_waddr),
        .i_wdata (w_vtx_wdata),
        .i_re    (w_vtx_re),
        .i_raddr (w_vtx_raddr),
        .o_rdata (w_vtx_rdata)
    );

    metf_size_ram #(
        .DEPTH (MAX_FACETS),
        .WIDTH (CW)
    ) u_size_ram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (w_size_we),
        .i_waddr    (FW'(i_facet_index)),
        .i_wdata    (w_size_wdata),
        .i_re       (w_size_re),
        .i_raddr    (w_size_raddr),
        .o_rdata    (w_size_rdata),
        .o_clr_busy (w_clr_busy)
    );

    metf_walker #(
        .MAX_FACETS  (MAX_FACETS),
        .MAX_VERTS   (MAX_VERTS),
        .VERTEX_BITS (VERTEX_BITS)
    ) u_walker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (w_start),
        .i_facet         (i_facet_index),
        .i_facets_in_use (r_facets_in_use),
        .o_busy          (w_busy),
        .o_size_re       (w_size_re),
        .o_size_raddr    (w_size_raddr),
        .i_size_rdata    (w_size_rdata),
        .o_vtx_re        (w_vtx_re),
        .o_vtx_raddr     (w_vtx_raddr),
        .i_vtx_rdata     (w_vtx_rdata),
        .o_res_valid     (o_out_valid),
        .o_res           (w_res),
        .i_res_stall     (i_out_stall)
    );

    // Result item fields.
    assign o_edge_position     = w_res.edge_position;
    assign o_neighbor_facet    = w_res.neighbor_facet;
    assign o_neighbor_position = w_res.neighbor_position;
    assign o_found             = w_res.found;
    assign o_last              = w_res.last;

endmodule
